// File: rtl/core/bigram_count_table_defines.svh
// ----------------------------------------------------------------------------
// Bigram count table assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BIGRAM_COUNT_TABLE_DEFINES_SVH
`define BIGRAM_COUNT_TABLE_DEFINES_SVH

// Same-cycle implication
`define BCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define BCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Invariant that holds at every edge out of reset
`define BCT_ASSERT_ALWAYS(label, cond, msg) \
   `BCT_ASSERT_NOW(label, 1'b1, cond, msg)

`endif

// File: rtl/core/bct_pkg.sv
// ----------------------------------------------------------------------------
// Bigram count table package
// Request codes, table entry layout and controller/datapath link types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bct_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 32;

   // Request codes
   localparam logic [1:0] REQ_PUSH  = 2'd0;
   localparam logic [1:0] REQ_COUNT = 2'd1;
   localparam logic [1:0] REQ_MAX   = 2'd2;

   // One stored pair with its count
   typedef struct packed {
      logic [VALUE_W-1:0] first;
      logic [VALUE_W-1:0] second;
      logic [COUNT_W-1:0] count;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic scan_en;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/core/bct_if.sv
// ----------------------------------------------------------------------------
// Bigram count table channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bct_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [31:0] value_a;
   logic signed [31:0] value_b;
   logic               start_sequence;

   modport source (output valid, req_type, value_a, value_b, start_sequence,
                   input ready);
   modport sink   (input valid, req_type, value_a, value_b, start_sequence,
                   output ready);
endinterface

interface bct_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic [31:0]        pair_count;
   logic signed [31:0] pair_first;
   logic signed [31:0] pair_second;
   logic [31:0]        total_grams;
   logic               table_full;

   modport source (output valid, found, pair_count, pair_first, pair_second,
                   total_grams, table_full, input ready);
   modport sink   (input valid, found, pair_count, pair_first, pair_second,
                   total_grams, table_full, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bct_datapath.sv
// ----------------------------------------------------------------------------
// Bigram count table datapath
// Pair memory, sequence state, table scan pipeline and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bct_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bct_pkg::ctrl_cmd_type cmd,
   output bct_pkg::dp_status_type    status,
   input  wire logic [1:0]           req_type,
   input  wire logic signed [31:0]   value_a,
   input  wire logic signed [31:0]   value_b,
   input  wire logic                 start_sequence,
   output logic                      found,
   output logic [31:0]               pair_count,
   output logic signed [31:0]        pair_first,
   output logic signed [31:0]        pair_second,
   output logic [31:0]               total_grams,
   output logic                      table_full
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   // Pair memory
   bct_pkg::entry_type mem [TABLE_DEPTH];

   // Sequence state
   logic [31:0]   prev_ff, prev_in;
   logic          have_prev_ff, have_prev_in;
   logic [CW-1:0] used_ff, used_in;
   logic [31:0]   total_ff, total_in;

   // Item registers
   logic [1:0]  op_ff;
   logic [31:0] elem_ff;
   logic [31:0] key_a_ff;
   logic [31:0] key_b_ff;
   logic        scan_on_ff, scan_on_in;

   // Scan pipeline
   logic [CW-1:0]      cnt_ff;
   logic               rd_vld_ff;
   logic [AW-1:0]      rd_idx_ff;
   bct_pkg::entry_type rd_data_ff;
   logic               sel_vld_ff;
   logic [AW-1:0]      sel_idx_ff;
   bct_pkg::entry_type sel_ff;

   logic issue;
   logic take;
   logic match;

   // Commit-side values
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   bct_pkg::entry_type wr_data;
   logic               res_found;
   logic [31:0]        res_count;
   logic [31:0]        res_first;
   logic [31:0]        res_second;
   logic               res_full;
   logic [31:0]        sel_inc;

   assign issue = cmd.scan_en && scan_on_ff && (cnt_ff != used_ff);
   assign match = (rd_data_ff.first == key_a_ff) && (rd_data_ff.second == key_b_ff);
   assign take  = (op_ff == bct_pkg::REQ_MAX) ?
                  (!sel_vld_ff || (rd_data_ff.count > sel_ff.count)) : match;
   assign status.scan_done = !rd_vld_ff && (!scan_on_ff || (cnt_ff == used_ff));
   assign sel_inc = (sel_ff.count == '1) ? sel_ff.count : sel_ff.count + 32'd1;

   // Decide the table update and the result of the item in hand
   always_comb begin
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      used_in      = used_ff;
      total_in     = total_ff;
      wr_en        = 1'b0;
      wr_addr      = sel_idx_ff;
      res_found    = 1'b0;
      res_count    = '0;
      res_first    = '0;
      res_second   = '0;
      res_full     = 1'b0;
      case (op_ff)
         bct_pkg::REQ_PUSH: begin
            if (have_prev_ff) begin
               if (total_ff != '1) begin
                  total_in = total_ff + 32'd1;
               end
               if (sel_vld_ff) begin
                  wr_en     = 1'b1;
                  res_found = 1'b1;
                  res_count = sel_inc;
               end else if (used_ff != DEPTH_C) begin
                  wr_en     = 1'b1;
                  wr_addr   = used_ff[AW-1:0];
                  used_in   = used_ff + CW'(1);
                  res_found = 1'b1;
                  res_count = 32'd1;
               end else begin
                  res_full = 1'b1;
               end
            end
            prev_in      = elem_ff;
            have_prev_in = 1'b1;
         end
         bct_pkg::REQ_COUNT: begin
            res_found = sel_vld_ff;
            res_count = sel_vld_ff ? sel_ff.count : '0;
         end
         bct_pkg::REQ_MAX: begin
            res_found  = sel_vld_ff;
            res_count  = sel_vld_ff ? sel_ff.count : '0;
            res_first  = sel_vld_ff ? sel_ff.first : '0;
            res_second = sel_vld_ff ? sel_ff.second : '0;
         end
         default: begin
         end
      endcase
      wr_data.first  = key_a_ff;
      wr_data.second = key_b_ff;
      wr_data.count  = res_count;
   end

   assign scan_on_in = (req_type == bct_pkg::REQ_PUSH) ?
                       (have_prev_ff && !start_sequence) :
                       ((req_type == bct_pkg::REQ_COUNT) || (req_type == bct_pkg::REQ_MAX));

   // Sequence state and scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         used_ff      <= '0;
         total_ff     <= '0;
         scan_on_ff   <= 1'b0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         sel_vld_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         if (cmd.load) begin
            scan_on_ff <= scan_on_in;
            cnt_ff     <= '0;
            sel_vld_ff <= 1'b0;
            // Drop the previous element and total on a new sequence
            if ((req_type == bct_pkg::REQ_PUSH) && start_sequence) begin
               have_prev_ff <= 1'b0;
               total_ff     <= '0;
            end
         end else begin
            if (issue) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
            if (rd_vld_ff && take) begin
               sel_vld_ff <= 1'b1;
            end
            if (cmd.commit) begin
               prev_ff      <= prev_in;
               have_prev_ff <= have_prev_in;
               used_ff      <= used_in;
               total_ff     <= total_in;
               scan_on_ff   <= 1'b0;
            end
         end
      end
   end

   // Capture the item and the selected entry
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_type;
         elem_ff  <= value_a;
         key_a_ff <= (req_type == bct_pkg::REQ_PUSH) ? prev_ff : value_a;
         key_b_ff <= (req_type == bct_pkg::REQ_PUSH) ? value_a : value_b;
      end
      if (rd_vld_ff && take) begin
         sel_ff     <= rd_data_ff;
         sel_idx_ff <= rd_idx_ff;
      end
   end

   // Read and write the pair memory
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[cnt_ff[AW-1:0]];
         rd_idx_ff  <= cnt_ff[AW-1:0];
      end
      if (cmd.commit && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         found       <= res_found;
         pair_count  <= res_count;
         pair_first  <= $signed(res_first);
         pair_second <= $signed(res_second);
         total_grams <= total_in;
         table_full  <= res_full;
      end
   end

`include "bigram_count_table_defines.svh"

   `BCT_ASSERT_ALWAYS(a_used_bound, used_ff <= DEPTH_C, "entry count beyond table depth")
   `BCT_ASSERT_NOW(a_scan_bound, scan_on_ff, cnt_ff <= used_ff, "scan ran past used entries")
   `BCT_ASSERT_NOW(a_hit_key, sel_vld_ff && (op_ff != bct_pkg::REQ_MAX), (sel_ff.first == key_a_ff) && (sel_ff.second == key_b_ff), "selected entry does not match key")
   `BCT_ASSERT_NEXT(a_full_no_write, cmd.commit && res_full, $stable(used_ff) && !found, "full table still inserted")

endmodule

`default_nettype wire

// File: rtl/core/bct_ctrl.sv
// ----------------------------------------------------------------------------
// Bigram count table controller
// Sequences load, table scan and commit, and owns the response valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bct_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output bct_pkg::ctrl_cmd_type      cmd,
   input  wire bct_pkg::dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // Decode commands from the current state
   always_comb begin
      cmd         = '0;
      cmd.load    = (state_ff == ST_IDLE) && req_valid;
      cmd.scan_en = (state_ff == ST_SCAN);
      cmd.commit  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Advance state and hold the response valid until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (status.scan_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (cmd.commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`include "bigram_count_table_defines.svh"

   `BCT_ASSERT_NOW(a_commit_slot, cmd.commit, !rsp_valid_ff || rsp_ready, "commit over a pending response")
   `BCT_ASSERT_NEXT(a_commit_valid, cmd.commit, rsp_valid_ff, "commit without response valid")
   `BCT_ASSERT_NEXT(a_load_scan, cmd.load, state_ff == ST_SCAN && !cmd.commit, "load did not start a scan")

endmodule

`default_nettype wire

// File: rtl/core/bigram_count_table.sv
// ----------------------------------------------------------------------------
// Bigram count table
// Counts adjacent element pairs in a table and answers count and max queries.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    req_type, value_a, value_b, start_sequence
//   rsp_bus   out   valid/ready    found, pair_count, pair_first, pair_second,
//                                  total_grams, table_full
//
// A scanning item goes from transfer to result through one read per stored pair,
// then a compare, a done and a commit step; an item that scans nothing (empty
// table, first push of a sequence, unused code) skips the reads and goes to commit.
// The next item can transfer the cycle after the commit. Reset is synchronous;
// the pair memory needs no clearing pass. A waiting result holds the next item
// before its commit until that result transfers.
`timescale 1ns / 1ps
`default_nettype none

module bigram_count_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bct_req_if.sink    req_bus,
   bct_rsp_if.source  rsp_bus
);

   bct_pkg::ctrl_cmd_type  cmd;
   bct_pkg::dp_status_type status;

   bct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   bct_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_bus.req_type),
      .value_a        (req_bus.value_a),
      .value_b        (req_bus.value_b),
      .start_sequence (req_bus.start_sequence),
      .found          (rsp_bus.found),
      .pair_count     (rsp_bus.pair_count),
      .pair_first     (rsp_bus.pair_first),
      .pair_second    (rsp_bus.pair_second),
      .total_grams    (rsp_bus.total_grams),
      .table_full     (rsp_bus.table_full)
   );

endmodule

`default_nettype wire

// File: sim/tb_bigram_count_table.sv
// ----------------------------------------------------------------------------
// Bigram count table testbench
// Drives push, count, max and unused requests into the pair table under random
// idling on both channels and checks every response against a behavioral
// model of the table, kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bigram_count_table;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1330;
   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
   localparam int IDLE_PCT     = 28;
   localparam int CALM_FIRST   = 350;
   localparam int CALM_LAST    = 550;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_CYCLES  = 500;
   localparam int PAUSE_AT     = 950;

   // Request code the block leaves undecoded
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic [1:0]         req_type;
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic               start_sequence;
   } pair_request_t;

   typedef struct {
      logic               found;
      logic [31:0]        pair_count;
      logic signed [31:0] pair_first;
      logic signed [31:0] pair_second;
      logic [31:0]        total_grams;
      logic               table_full;
   } pair_result_t;

   // Pair table model and queue of pending responses
   class bigram_scoreboard;
      logic [31:0]  prev_elem;
      bit           have_prev;
      logic [31:0]  first_mem [TABLE_DEPTH];
      logic [31:0]  second_mem [TABLE_DEPTH];
      logic [31:0]  count_mem [TABLE_DEPTH];
      int           used;
      logic [31:0]  gram_total;
      pair_result_t pending_q [$];
      int           errors;

      function new();
         prev_elem  = '0;
         have_prev  = 1'b0;
         used       = 0;
         gram_total = '0;
         errors     = 0;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      task report(input string msg);
         if (errors < 40) begin
            $display("%0t mismatch: %s", $realtime, msg);
         end
         errors++;
      endtask

      function int lookup(input logic [31:0] a, input logic [31:0] b);
         for (int i = 0; i < used; i++) begin
            if (first_mem[i] == a && second_mem[i] == b) return i;
         end
         return -1;
      endfunction

      // Advance the table for one accepted request and queue its response
      function void note_request(input pair_request_t it);
         pair_result_t r;
         int           idx;
         int           best;
         r = '{found: 1'b0, pair_count: '0, pair_first: '0, pair_second: '0,
               total_grams: '0, table_full: 1'b0};
         case (it.req_type)
            bct_pkg::REQ_PUSH: begin
               if (it.start_sequence) begin
                  have_prev  = 1'b0;
                  gram_total = '0;
               end
               if (have_prev) begin
                  if (gram_total != 32'hffff_ffff) gram_total++;
                  idx = lookup(prev_elem, it.value_a);
                  if (idx >= 0) begin
                     if (count_mem[idx] != 32'hffff_ffff) count_mem[idx]++;
                     r.found      = 1'b1;
                     r.pair_count = count_mem[idx];
                  end else if (used < TABLE_DEPTH) begin
                     first_mem[used]  = prev_elem;
                     second_mem[used] = it.value_a;
                     count_mem[used]  = 32'd1;
                     used++;
                     r.found      = 1'b1;
                     r.pair_count = 32'd1;
                  end else begin
                     r.table_full = 1'b1;
                  end
               end
               prev_elem = it.value_a;
               have_prev = 1'b1;
            end
            bct_pkg::REQ_COUNT: begin
               idx = lookup(it.value_a, it.value_b);
               if (idx >= 0) begin
                  r.found      = 1'b1;
                  r.pair_count = count_mem[idx];
               end
            end
            bct_pkg::REQ_MAX: begin
               if (used > 0) begin
                  // Strictly greater keeps the earliest entry on a tie
                  best = 0;
                  for (int i = 1; i < used; i++) begin
                     if (count_mem[i] > count_mem[best]) best = i;
                  end
                  r.found       = 1'b1;
                  r.pair_count  = count_mem[best];
                  r.pair_first  = first_mem[best];
                  r.pair_second = second_mem[best];
               end
            end
            default: ;
         endcase
         r.total_grams = gram_total;
         pending_q.push_back(r);
      endfunction

      // Compare one response transfer with the oldest pending response
      task check_response(input pair_result_t got);
         pair_result_t want;
         if (pending_q.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = pending_q.pop_front();
         if (got.found !== want.found)
            report($sformatf("found %b, want %b", got.found, want.found));
         if (got.pair_count !== want.pair_count)
            report($sformatf("pair_count %0d, want %0d", got.pair_count, want.pair_count));
         if (got.pair_first !== want.pair_first)
            report($sformatf("pair_first %0d, want %0d", got.pair_first, want.pair_first));
         if (got.pair_second !== want.pair_second)
            report($sformatf("pair_second %0d, want %0d", got.pair_second,
                             want.pair_second));
         if (got.total_grams !== want.total_grams)
            report($sformatf("total_grams %0d, want %0d", got.total_grams,
                             want.total_grams));
         if (got.table_full !== want.table_full)
            report($sformatf("table_full %b, want %b", got.table_full, want.table_full));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   bct_req_if req_bus ();
   bct_rsp_if rsp_bus ();

   bigram_count_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bigram_scoreboard   sb = new();
   logic signed [31:0] value_pool [8];
   bit                 sender_calm;
   int                 results_seen;
   int                 hold_left;
   bit                 hold_done;
   int                 cycle_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // End the run if it stalls
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_bigram_count_table: errors");
      $finish;
   end

   // Check response transfers and pick the next ready value
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         results_seen = 0;
         hold_left    = 0;
         hold_done    = 1'b0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            sb.check_response('{found: rsp_bus.found, pair_count: rsp_bus.pair_count,
                                pair_first: rsp_bus.pair_first,
                                pair_second: rsp_bus.pair_second,
                                total_grams: rsp_bus.total_grams,
                                table_full: rsp_bus.table_full});
            results_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AT) begin
            // Hold off long enough for the block to back up its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   function automatic pair_request_t make_request(input logic [1:0] kind,
                                                  input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic start);
      pair_request_t it;
      it.req_type       = kind;
      it.value_a        = a;
      it.value_b        = b;
      it.start_sequence = start;
      return it;
   endfunction

   // Mostly pool values so pairs repeat, with extremes and wide values mixed in
   function automatic logic signed [31:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 82) return value_pool[$urandom_range(0, 7)];
      if (roll < 88) begin
         case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom();
   endfunction

   function automatic pair_request_t random_request();
      pair_request_t it;
      int unsigned   roll;
      roll = $urandom_range(0, 99);
      it.value_a        = pick_value();
      it.value_b        = $urandom();
      it.start_sequence = ($urandom_range(0, 99) < 8);
      if (roll < 70) begin
         it.req_type = bct_pkg::REQ_PUSH;
      end else if (roll < 85) begin
         it.req_type = bct_pkg::REQ_COUNT;
         it.value_b  = pick_value();
      end else if (roll < 96) begin
         it.req_type = bct_pkg::REQ_MAX;
      end else begin
         it.req_type = REQ_UNUSED;
      end
      return it;
   endfunction

   // Offer one request, idling first at random, and hold until it transfers
   task automatic send_request(input pair_request_t it);
      if (!sender_calm) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid          <= 1'b0;
            req_bus.req_type       <= $urandom();
            req_bus.value_a        <= $urandom();
            req_bus.value_b        <= $urandom();
            req_bus.start_sequence <= $urandom();
            @(posedge clock);
         end
      end
      req_bus.valid          <= 1'b1;
      req_bus.req_type       <= it.req_type;
      req_bus.value_a        <= it.value_a;
      req_bus.value_b        <= it.value_b;
      req_bus.start_sequence <= it.start_sequence;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.note_request(it);
   endtask

   // Drop valid and wait for every outstanding response
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      pair_request_t directed_q [$];

      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.req_type       <= bct_pkg::REQ_PUSH;
      req_bus.value_a        <= '0;
      req_bus.value_b        <= '0;
      req_bus.start_sequence <= 1'b0;
      sender_calm             = 1'b0;

      value_pool[0] = 32'sd0;
      value_pool[1] = -32'sd1;
      value_pool[2] = VAL_MIN;
      value_pool[3] = VAL_MAX;
      value_pool[4] = $urandom();
      value_pool[5] = $urandom();
      value_pool[6] = $signed($urandom_range(0, 15)) - 32'sd8;
      value_pool[7] = $signed($urandom_range(0, 15)) + 32'sd8;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty table queries, first element with no start flag, ties on max
      directed_q.push_back(make_request(bct_pkg::REQ_MAX, $urandom(), $urandom(), 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_COUNT, 32'sd0, 32'sd0, 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, VAL_MIN, $urandom(), 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, VAL_MAX, $urandom(), 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, 32'sd0, $urandom(), 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_MAX, 32'sd0, 32'sd0, 1'b1));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, VAL_MIN, $urandom(), 1'b1));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, VAL_MAX, $urandom(), 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_MAX, VAL_MAX, VAL_MIN, 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_COUNT, VAL_MAX, 32'sd0, 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_COUNT, 32'sd0, VAL_MAX, 1'b1));
      directed_q.push_back(make_request(REQ_UNUSED, $urandom(), $urandom(), 1'b1));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, -32'sd1, $urandom(), 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, 32'sh5555_5555, $urandom(),
                                        1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, 32'shAAAA_AAAA, $urandom(),
                                        1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, 32'sh5555_5555, $urandom(),
                                        1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, 32'shAAAA_AAAA, $urandom(),
                                        1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_COUNT, 32'sh5555_5555,
                                        32'shAAAA_AAAA, 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_MAX, -32'sd1, -32'sd1, 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, VAL_MAX, $urandom(), 1'b1));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, VAL_MAX, $urandom(), 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_PUSH, VAL_MAX, $urandom(), 1'b0));
      directed_q.push_back(make_request(bct_pkg::REQ_COUNT, VAL_MAX, VAL_MAX, 1'b0));
      foreach (directed_q[i]) send_request(directed_q[i]);

      // Random traffic; the table fills and then mostly hits or overflows
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PAUSE_AT) drain_results();
         sender_calm = (n >= CALM_FIRST && n < CALM_LAST);
         send_request(random_request());
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.report("responses still outstanding at end of run");

      if (sb.errors == 0) begin
         $display("tb_bigram_count_table: clean");
      end else begin
         $display("tb_bigram_count_table: errors");
      end
      $finish;
   end

endmodule
